// File: rtl/lzd_pkg.sv
// lzd_pkg: sizes, token classes and beat structs for the LZ77 token decoder.
// Used by the channel interfaces and by every module of the decoder except lzd_ram.
`timescale 1ns / 1ps

package lzd_pkg;

  localparam int HISTORY_DEPTH = 4096;
  localparam int DISTANCE_BITS = 12;
  localparam int LENGTH_BITS   = 4;
  localparam int BYTE_BITS     = 8;
  localparam int ADDR_BITS     = $clog2(HISTORY_DEPTH);

  // Token class as decided by the front end
  typedef enum logic [1:0] {
    KIND_LIT  = 2'd0,
    KIND_COPY = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  // Back-end sequencer state
  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_COPY = 1'b1
  } back_state_t;

  // Classified token passed from front to back
  typedef struct packed {
    kind_t                     kind;
    logic [BYTE_BITS-1:0]      literal;
    logic [DISTANCE_BITS-1:0]  distance;
    logic [LENGTH_BITS-1:0]    copy_length;
  } cmd_t;

  // One result beat held in the output queue
  typedef struct packed {
    logic [BYTE_BITS-1:0] out_byte;
    logic                 last;
    logic                 bad_distance;
  } out_beat_t;

endpackage

// File: rtl/lzd_if.sv
// lzd_token_if and lzd_byte_if: valid/ready channels for tokens and bytes.
// Depends on lzd_pkg for field widths.
`timescale 1ns / 1ps

interface lzd_token_if import lzd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     is_match;
  logic [BYTE_BITS-1:0]     literal;
  logic [DISTANCE_BITS-1:0] distance;
  logic [LENGTH_BITS-1:0]   copy_length;

  modport source(output valid, is_match, literal, distance, copy_length, input ready);
  modport sink(input valid, is_match, literal, distance, copy_length, output ready);
endinterface

interface lzd_byte_if import lzd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] out_byte;
  logic                 last;
  logic                 bad_distance;

  modport source(output valid, out_byte, last, bad_distance, input ready);
  modport sink(input valid, out_byte, last, bad_distance, output ready);
endinterface

// File: rtl/lzd_ram.sv
// lzd_ram: generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read port returning the old contents on a collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/lzd_front.sv
// lzd_front: accepts tokens, classifies them and queues commands for the back end.
// Depends on lzd_pkg and lzd_token_if.
`timescale 1ns / 1ps

module lzd_front import lzd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  lzd_token_if.sink     in_chan,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output cmd_t          cmd
);

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept, push, pop;
  cmd_t       new_cmd;

  // Classify the incoming token
  always_comb begin
    new_cmd.literal     = in_chan.literal;
    new_cmd.distance    = in_chan.distance;
    new_cmd.copy_length = in_chan.copy_length;
    if (!in_chan.is_match) begin
      new_cmd.kind = KIND_LIT;
    end else if (in_chan.distance == '0) begin
      new_cmd.kind = KIND_BAD;
    end else begin
      new_cmd.kind = KIND_COPY;
    end
  end

  // Drop zero-length matches: accepted, never queued
  assign in_chan.ready = (cnt_r != 2'd2);
  assign accept        = in_chan.valid && in_chan.ready;
  assign push          = accept && !(in_chan.is_match && in_chan.copy_length == '0);
  assign cmd_valid     = (cnt_r != 2'd0);
  assign cmd           = q_r[rp_r];
  assign pop           = cmd_valid && cmd_ready;

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  // Hold queue pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the queued command
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= new_cmd;
    end
  end

endmodule

// File: rtl/lzd_back.sv
// lzd_back: copy engine that emits one byte per cycle from the history RAM while
// its two-beat output queue has room. Depends on lzd_pkg, lzd_byte_if and lzd_ram.
`timescale 1ns / 1ps

module lzd_back import lzd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  cmd_t          cmd,
  lzd_byte_if.source    out_chan
);

  back_state_t            state_r, state_nxt;
  cmd_t                   cur_r, cur_nxt, cur;
  logic [LENGTH_BITS-1:0] idx_r, idx_nxt, idx;
  logic [ADDR_BITS-1:0]   ip_r, ip_nxt;
  logic                   wrap_r, wrap_nxt;
  logic                   cur_vld, last_byte, room, issue, writes;
  logic [ADDR_BITS-1:0]   rd_addr;
  logic                   far, filled, hit;
  logic [2:0]             occ;

  // Read stage registers
  logic                   b_valid_r;
  kind_t                  b_kind_r;
  logic [BYTE_BITS-1:0]   b_lit_r;
  logic [ADDR_BITS-1:0]   b_addr_r;
  logic                   b_hit_r, b_fill_r, b_last_r;
  logic [BYTE_BITS-1:0]   b_data, prev_r, ram_q;
  logic                   ram_we;

  // Output queue
  out_beat_t              ent_r [2];
  logic                   owp_r, orp_r;
  logic [1:0]             ocnt_r;
  logic                   out_pop;

  assign out_pop = out_chan.valid && out_chan.ready;
  assign occ     = 3'(ocnt_r) + 3'(b_valid_r);
  assign room    = (occ < 3'd2) || (occ == 3'd2 && out_pop);

  // Current token: the one in progress, else the queue head
  assign cur     = (state_r == BK_COPY) ? cur_r : cmd;
  assign cur_vld = (state_r == BK_COPY) || cmd_valid;
  assign idx     = (state_r == BK_COPY) ? idx_r : '0;

  assign last_byte = (cur.kind != KIND_COPY) || ((idx + LENGTH_BITS'(1)) == cur.copy_length);
  assign issue     = cur_vld && room;
  assign writes    = issue && (cur.kind != KIND_BAD);

  // Source address, whether it was ever written, and a write-then-read collision
  assign rd_addr = ip_r - ADDR_BITS'(cur.distance);
  assign far     = 32'(cur.distance) > 32'(HISTORY_DEPTH);
  assign filled  = !far && (wrap_r || (rd_addr < ip_r));
  assign hit     = b_valid_r && (b_kind_r != KIND_BAD) && (rd_addr == b_addr_r);

  // Sequencer: next state, token hold and byte index
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    cmd_ready = (state_r == BK_IDLE) && room;
    if (issue) begin
      if (last_byte) begin
        state_nxt = BK_IDLE;
      end else begin
        state_nxt = BK_COPY;
        cur_nxt   = cur;
        idx_nxt   = idx + LENGTH_BITS'(1);
      end
    end
  end

  // Advance the history write pointer
  always_comb begin
    ip_nxt   = ip_r;
    wrap_nxt = wrap_r;
    if (writes) begin
      ip_nxt = ip_r + ADDR_BITS'(1);
      if (ip_r == '1) begin
        wrap_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      ip_r      <= '0;
      wrap_r    <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ip_r      <= ip_nxt;
      wrap_r    <= wrap_nxt;
      b_valid_r <= issue;
    end
  end

  // Carry the issued byte into the read stage
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    idx_r <= idx_nxt;
    if (issue) begin
      b_kind_r <= cur.kind;
      b_lit_r  <= cur.literal;
      b_addr_r <= ip_r;
      b_hit_r  <= hit;
      b_fill_r <= filled;
      b_last_r <= last_byte;
    end
    if (b_valid_r) begin
      prev_r <= b_data;
    end
  end

  lzd_ram #(
    .WIDTH(BYTE_BITS),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (b_addr_r),
    .wdata (b_data),
    .re    (issue && cur.kind == KIND_COPY),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Select the byte: literal, forwarded, stored, or zero for never-written history or a bad distance
  always_comb begin
    unique case (b_kind_r)
      KIND_LIT:  b_data = b_lit_r;
      KIND_COPY: b_data = b_hit_r ? prev_r : (b_fill_r ? ram_q : '0);
      default:   b_data = '0;
    endcase
  end

  assign ram_we = b_valid_r && (b_kind_r != KIND_BAD);

  // Output queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (b_valid_r) begin
        owp_r <= !owp_r;
      end
      if (out_pop) begin
        orp_r <= !orp_r;
      end
      ocnt_r <= ocnt_r + {1'b0, b_valid_r} - {1'b0, out_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      ent_r[owp_r] <= '{out_byte: b_data, last: b_last_r,
                        bad_distance: (b_kind_r == KIND_BAD)};
    end
  end

  assign out_chan.valid        = (ocnt_r != 2'd0);
  assign out_chan.out_byte     = ent_r[orp_r].out_byte;
  assign out_chan.last         = ent_r[orp_r].last;
  assign out_chan.bad_distance = ent_r[orp_r].bad_distance;

endmodule

// File: rtl/lz77_token_decoder_core.sv
// lz77_token_decoder_core: top level of the LZ77 token decoder.
// Depends on lzd_pkg, lzd_if, lzd_front and lzd_back.
`timescale 1ns / 1ps

// Tokens enter on in_chan and decoded bytes leave on out_chan, one byte per
// beat with last marking the final byte of each token. The history is a
// 4096-byte ring in a single-port-read RAM, read once per copied byte, so
// the copy engine sustains one byte per cycle while the output accepts bytes:
// a literal or bad-distance token yields one byte, a match yields copy_length
// bytes and a zero-length match yields none. The first byte of a token passes
// through the front queue, the read stage and the output queue before it is valid.
// A wrap flag and a compare against the write pointer make unwritten history
// read as zero, so the block accepts tokens right after reset.
module lz77_token_decoder_core import lzd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lzd_token_if.sink  in_chan,
  lzd_byte_if.source out_chan
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  lzd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  lzd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_chan  (out_chan)
  );

  // Zero-length matches never reach the copy engine
  a_no_empty_copy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && cmd.kind == KIND_COPY) |-> (cmd.copy_length != '0))
    else $error("copy command with zero length");

  // A bad-distance command came from a zero distance
  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && cmd.kind == KIND_BAD) |-> (cmd.distance == '0))
    else $error("bad-distance command with nonzero distance");

  // A flagged beat is a single zero byte ending its token
  a_bad_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.bad_distance) |-> (out_chan.last && out_chan.out_byte == '0))
    else $error("bad-distance beat malformed");

endmodule
